[hdl/pnvm_pkg.sv]
// ----------------------------------------------------------------------------
// Polyphonic NCO voice mixer package
// Shared request and result types, operation and waveform codes, sequencer
// states and the note frequency table.
// ----------------------------------------------------------------------------
package pnvm_pkg;

  localparam int unsigned MAX_VOICES_DEF   = 16;
  localparam int unsigned NOTE_COUNT_DEF   = 84;
  localparam int unsigned SINE_ENTRIES_DEF = 1028;

  localparam int unsigned NOTE_TABLE_LEN   = 84;
  localparam logic [63:0] SAMPLE_RATE      = 64'd22050;
  localparam logic [63:0] PI_Q30           = 64'd3373259426;

  localparam logic [3:0]  MIN_OCTAVE       = 4'd2;
  localparam logic [3:0]  MAX_KEY          = 4'd11;
  localparam logic [31:0] PHASE_HALF       = 32'h7FFF_FFFF;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 8'd1;

  localparam logic [3:0] VOLUME_RESET = 4'd4;
  localparam logic [3:0] VOLUME_FULL  = 4'd8;

  localparam logic [8:0] OFFSET_SQUARE = 9'd64;
  localparam logic [8:0] OFFSET_OTHER  = 9'd128;
  localparam logic signed [8:0] SQUARE_HIGH = 9'sd63;
  localparam logic signed [8:0] SQUARE_LOW  = -9'sd64;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SINE     = 2'd3
  } wave_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOTE,
    ST_REL_RD,
    ST_REL_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_TICK_RUN,
    ST_TICK_SCALE,
    ST_TICK_DIV,
    ST_TICK_OUT
  } seq_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  octave;
    logic [3:0]  key;
    logic [14:0] pitch_bend;
  } req_t;

  typedef struct packed {
    logic [8:0] sample_out;
    logic [4:0] active_voices;
  } res_t;

  // Equal-tempered frequencies in Hz, truncated, starting at C2.
  localparam logic [15:0] NOTE_FREQ [NOTE_TABLE_LEN] = '{
    16'd65,   16'd69,   16'd73,   16'd77,   16'd82,   16'd87,
    16'd92,   16'd97,   16'd103,  16'd110,  16'd116,  16'd123,
    16'd130,  16'd138,  16'd146,  16'd155,  16'd164,  16'd174,
    16'd184,  16'd195,  16'd207,  16'd220,  16'd233,  16'd246,
    16'd261,  16'd277,  16'd293,  16'd311,  16'd329,  16'd349,
    16'd369,  16'd391,  16'd415,  16'd440,  16'd466,  16'd493,
    16'd523,  16'd554,  16'd587,  16'd622,  16'd659,  16'd698,
    16'd739,  16'd783,  16'd830,  16'd880,  16'd932,  16'd987,
    16'd1046, 16'd1108, 16'd1174, 16'd1244, 16'd1318, 16'd1396,
    16'd1479, 16'd1567, 16'd1661, 16'd1760, 16'd1864, 16'd1975,
    16'd2093, 16'd2217, 16'd2349, 16'd2489, 16'd2637, 16'd2793,
    16'd2959, 16'd3135, 16'd3322, 16'd3520, 16'd3729, 16'd3951,
    16'd4186, 16'd4434, 16'd4698, 16'd4978, 16'd5274, 16'd5587,
    16'd5919, 16'd6271, 16'd6644, 16'd7040, 16'd7458, 16'd7902
  };

endpackage

[hdl/polyphonic_nco_voice_mixer.sv]
// ----------------------------------------------------------------------------
// Polyphonic NCO voice mixer
// Voice table of note steps and phases in synchronous memories, a pipelined
// per-voice walk on each sample tick and an iterative divide by voice count.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. busy_o then
// stays high through ST_NOTE on a press, and on a release of a valid note with
// voices in the table also through the read-compare loop and then the
// read-write loop over the step memory, a read state and a compare or write
// state per position. On a tick, one voice enters the phase pipeline per cycle
// and the pipeline then drains. ST_TICK_SCALE scales the sum. Unless there are
// no voices, the divider then divides it by the voice count, one step per bit
// of the 14-bit mixed sum, and hands over the quotient. ST_TICK_OUT registers
// the result. The tick result appears on res_o for exactly one cycle with
// res_valid_o high, right after busy_o drops. There is no back-pressure on
// results, so the receiver must take it then. Presses and releases give no
// result.
module polyphonic_nco_voice_mixer
  import pnvm_pkg::*;
#(
  parameter int unsigned MAX_VOICES   = MAX_VOICES_DEF,
  parameter int unsigned NOTE_COUNT   = NOTE_COUNT_DEF,
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  req_t                  req_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_VOICES + 1);
  localparam int unsigned NOTE_W  = $clog2(NOTE_COUNT);
  localparam int unsigned SIDX_W  = $clog2(SINE_ENTRIES);
  localparam int unsigned SPROD_W = 32 + SIDX_W;
  localparam int unsigned SUM_W   = CNT_W + 9;
  localparam int unsigned MUL_W   = SUM_W + 5;

  typedef logic [31:0] step_tbl_t [NOTE_COUNT];
  typedef logic [7:0]  sine_tbl_t [SINE_ENTRIES];

  function automatic step_tbl_t build_note_steps();
    step_tbl_t tbl;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      tbl[i] = 32'((64'(NOTE_FREQ[i]) << 32) / SAMPLE_RATE);
    end
    return tbl;
  endfunction

  // Sine by Taylor series in Q30, with a small bias so the peaks reach 127.
  function automatic sine_tbl_t build_sine();
    sine_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic        neg;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x   = (64'd2 * PI_Q30 * 64'(i)) / 64'(SINE_ENTRIES);
      neg = 1'b0;
      if (x >= PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > (PI_Q30 >> 1)) begin
        x = PI_Q30 - x;
      end
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      for (int k = 1; k <= 9; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          s = (s > t) ? s - t : 64'd0;
        end else begin
          s = s + t;
        end
      end
      v = (64'd127 * s + 64'd16384) >> 30;
      if (v > 64'd127) begin
        v = 64'd127;
      end
      tbl[i] = neg ? 8'(64'd0 - v) : 8'(v);
    end
    return tbl;
  endfunction

  localparam step_tbl_t NOTE_STEP = build_note_steps();
  localparam sine_tbl_t SINE_ROM  = build_sine();

  // Sequencer and configuration.
  seq_e             state_q, state_d;
  req_t             req_q;
  logic [1:0]       waveform_q;
  logic [3:0]       volume_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] pos_q;
  logic [CNT_W-1:0] pos_nxt;
  logic [CNT_W:0]   pos_two;
  logic             more;
  logic             more2;
  logic             accept;
  logic [31:0]      key_step_q;

  // Note lookup.
  logic [3:0]        oct_m2;
  logic [7:0]        note_num;
  logic              note_ok;
  logic [NOTE_W-1:0] note_idx;
  logic [31:0]       note_step;

  // Memories.
  logic [31:0]      step_mem  [MAX_VOICES];
  logic [31:0]      phase_mem [MAX_VOICES];
  logic             ph_vld_q  [MAX_VOICES];
  logic [IDX_W-1:0] rd_addr;
  logic             step_we;
  logic [IDX_W-1:0] step_waddr;
  logic [31:0]      step_rd_q;
  logic [31:0]      ph_rd_q;
  logic             ph_vld_rd_q;

  // Control from the output decoder.
  logic issue;
  logic found;
  logic pipe_empty;
  logic count_inc;
  logic count_dec;
  logic div_start;
  logic res_load;

  // Phase pipeline.
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [IDX_W-1:0]        pos1_q, pos2_q;
  logic [46:0]             inc_prod;
  logic [31:0]             inc_q;
  logic [31:0]             ph_old_q;
  logic [31:0]             ph_new;
  logic [31:0]             ph_q;
  logic [31:0]             ph_neg;
  logic [SPROD_W-1:0]      sin_prod;
  logic [SIDX_W-1:0]       sidx_q;
  logic signed [8:0]       wval;
  logic signed [8:0]       wval4_q;
  logic signed [8:0]       wval5_q;
  logic [7:0]              sine_q;
  logic signed [8:0]       voice_val;
  logic signed [SUM_W-1:0] acc_q;

  // Scaling, divide and result.
  logic [3:0]              vol_eff;
  logic signed [MUL_W-1:0] acc_ext;
  logic signed [MUL_W-1:0] vol_ext;
  logic signed [MUL_W-1:0] vmul;
  logic signed [MUL_W-1:0] vtrunc;
  logic signed [MUL_W-1:0] vshift;
  logic signed [SUM_W-1:0] scaled;
  logic [SUM_W-1:0]        scaled_mag;
  logic                    neg_q;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic [SUM_W-1:0]        quo_q;
  logic [SUM_W-1:0]        quo_signed;
  logic [8:0]              offset;
  logic                    res_valid_q;
  res_t                    res_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign pos_nxt = pos_q + 1'b1;
  assign pos_two = {1'b0, pos_q} + (CNT_W + 1)'(2);
  assign more    = pos_nxt < count_q;
  assign more2   = pos_two < {1'b0, count_q};

  // Note number is 12 * (octave - 2) + key.
  assign oct_m2    = req_q.octave - MIN_OCTAVE;
  assign note_num  = 8'({oct_m2, 3'b000}) + 8'({oct_m2, 2'b00}) + 8'(req_q.key);
  assign note_ok   = (req_q.octave >= MIN_OCTAVE) && (req_q.key <= MAX_KEY) &&
                     (note_num < 8'(NOTE_COUNT));
  assign note_idx  = note_num[NOTE_W-1:0];
  assign note_step = NOTE_STEP[note_idx];

  assign found      = (step_rd_q == key_step_q);
  assign issue      = (state_q == ST_TICK_RUN) && (pos_q < count_q);
  assign pipe_empty = !(v1_q || v2_q || v3_q || v4_q || v5_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.operation)
            OP_TICK:    state_d = ST_TICK_RUN;
            OP_PRESS:   state_d = ST_NOTE;
            OP_RELEASE: state_d = ST_NOTE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_NOTE: begin
        if (note_ok && (req_q.operation == OP_RELEASE) && (count_q != '0)) begin
          state_d = ST_REL_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REL_RD:   state_d = ST_REL_CMP;
      ST_REL_CMP: begin
        if (found) begin
          state_d = more ? ST_SHIFT_RD : ST_IDLE;
        end else begin
          state_d = more ? ST_REL_RD : ST_IDLE;
        end
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = more2 ? ST_SHIFT_RD : ST_IDLE;
      ST_TICK_RUN: begin
        if (!issue && pipe_empty) begin
          state_d = ST_TICK_SCALE;
        end
      end
      ST_TICK_SCALE: state_d = (count_q == '0) ? ST_TICK_OUT : ST_TICK_DIV;
      ST_TICK_DIV: begin
        if (div_done) begin
          state_d = ST_TICK_OUT;
        end
      end
      ST_TICK_OUT: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    rd_addr    = pos_q[IDX_W-1:0];
    step_we    = 1'b0;
    step_waddr = pos_q[IDX_W-1:0];
    count_inc  = 1'b0;
    count_dec  = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    case (state_q)
      ST_NOTE: begin
        step_waddr = count_q[IDX_W-1:0];
        if (note_ok && (req_q.operation == OP_PRESS) &&
            (count_q < CNT_W'(MAX_VOICES))) begin
          step_we   = 1'b1;
          count_inc = 1'b1;
        end
      end
      ST_REL_CMP:    count_dec = found && !more;
      ST_SHIFT_RD:   rd_addr   = pos_nxt[IDX_W-1:0];
      ST_SHIFT_WR: begin
        step_we   = 1'b1;
        count_dec = !more2;
      end
      ST_TICK_SCALE: div_start = (count_q != '0);
      ST_TICK_OUT:   res_load  = 1'b1;
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      waveform_q  <= WAVE_SAW;
      volume_q    <= VOLUME_RESET;
      count_q     <= '0;
      pos_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        ph_vld_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WAVEFORM) begin
          waveform_q <= cfg_data_i[1:0];
        end else if (cfg_index_i == CFG_VOLUME) begin
          volume_q <= cfg_data_i[3:0];
        end
      end
      if (count_inc) begin
        count_q <= count_q + 1'b1;
      end else if (count_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (state_q == ST_IDLE) begin
        pos_q <= '0;
      end else if (issue || (state_q == ST_SHIFT_WR) ||
                   ((state_q == ST_REL_CMP) && !found)) begin
        pos_q <= pos_nxt;
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (v2_q) begin
        ph_vld_q[pos2_q] <= 1'b1;
      end
      res_valid_q <= res_load;
    end
  end

  // Voice step and phase memories, one read port and one write port each.
  always_ff @(posedge clk_i) begin
    if (step_we) begin
      step_mem[step_waddr] <= (state_q == ST_NOTE) ? note_step : step_rd_q;
    end
    step_rd_q <= step_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      phase_mem[pos2_q] <= ph_new;
    end
    ph_rd_q     <= phase_mem[rd_addr];
    ph_vld_rd_q <= ph_vld_q[rd_addr];
  end

  // Phase pipeline: read, step times bend, phase update, waveform, sine read.
  assign inc_prod = 47'(step_rd_q) * 47'(req_q.pitch_bend);
  assign ph_new   = ph_old_q + inc_q;
  assign ph_neg   = 32'd0 - ph_q;
  assign sin_prod = SPROD_W'(ph_q) * SPROD_W'(SINE_ENTRIES - 1);

  always_comb begin
    case (waveform_q)
      WAVE_SAW:      wval = {~ph_q[31], ~ph_q[31], ph_q[30:24]};
      WAVE_SQUARE:   wval = (ph_q < PHASE_HALF) ? SQUARE_HIGH : SQUARE_LOW;
      WAVE_TRIANGLE: wval = (ph_q < PHASE_HALF) ? {1'b0, ph_q[31:24]}
                                                : {1'b0, ph_neg[31:24]};
      default:       wval = '0;
    endcase
  end

  assign voice_val = (waveform_q == WAVE_SINE) ? {sine_q[7], sine_q} : wval5_q;

  always_ff @(posedge clk_i) begin
    pos1_q   <= rd_addr;
    pos2_q   <= pos1_q;
    inc_q    <= inc_prod[45:14];
    ph_old_q <= ph_vld_rd_q ? ph_rd_q : 32'd0;
    ph_q     <= ph_new;
    sidx_q   <= sin_prod[32 +: SIDX_W];
    wval4_q  <= wval;
    sine_q   <= SINE_ROM[sidx_q];
    wval5_q  <= wval4_q;
    if (accept) begin
      req_q <= req_i;
      acc_q <= '0;
    end else if (v5_q) begin
      acc_q <= acc_q + {{(SUM_W - 9){voice_val[8]}}, voice_val};
    end
    if (state_q == ST_NOTE) begin
      key_step_q <= note_step;
    end
  end

  // Volume: a right shift for saw, eighths truncated toward zero otherwise.
  assign vol_eff = (volume_q > VOLUME_FULL) ? VOLUME_FULL : volume_q;
  assign acc_ext = {{5{acc_q[SUM_W-1]}}, acc_q};
  assign vol_ext = {{(MUL_W - 4){1'b0}}, vol_eff};
  assign vmul    = acc_ext * vol_ext;
  assign vtrunc  = vmul + (vmul[MUL_W-1] ? MUL_W'(7) : MUL_W'(0));
  assign vshift  = vtrunc >>> 3;

  always_comb begin
    if (waveform_q == WAVE_SAW) begin
      scaled = acc_q >>> (VOLUME_FULL - vol_eff);
    end else begin
      scaled = vshift[SUM_W-1:0];
    end
  end

  assign scaled_mag = scaled[SUM_W-1] ? (SUM_W'(0) - scaled) : scaled;

  pnvm_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scaled_mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_signed = neg_q ? (SUM_W'(0) - quo_q) : quo_q;
  assign offset     = (waveform_q == WAVE_SQUARE) ? OFFSET_SQUARE : OFFSET_OTHER;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TICK_SCALE) begin
      neg_q <= scaled[SUM_W-1];
      quo_q <= '0;
    end else if (div_done) begin
      quo_q <= div_quo;
    end
    if (res_load) begin
      res_q.sample_out    <= quo_signed[8:0] + offset;
      res_q.active_voices <= 5'(count_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The voice count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VOICES))
    else $error("voice count beyond table size");

  // One strobe per tick: never two result cycles in a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held longer than one cycle");

  // The reported voice count matches the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.active_voices == 5'(count_q)))
    else $error("reported voice count differs from table");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_TICK_DIV))
    else $error("divider finished outside of the divide step");

endmodule

[hdl/pnvm_div.sv]
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module pnvm_div #(
  parameter int unsigned DVD_W = 14,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   rem_shift;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  assign rem_shift = {rem_q, quo_q[DVD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};
  assign fits      = rem_shift >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNT_W'(DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic NCO voice mixer testbench
// Drives press, release and tick requests through the start/busy handshake
// and checks every tick sample against a cycle-free model of the voice table.
// The model runs when a request is taken, so it sees the same configuration
// as the block. Register settings change only between phases, once the block
// is idle. The sender idles at several rates from phase to phase.
// ----------------------------------------------------------------------------
module tb
  import pnvm_pkg::*;
();

  localparam int VOICES     = 16;
  localparam int NOTES      = 84;
  localparam int SINE_LEN   = 1028;
  localparam int LOW_OCTAVE = 2;
  localparam int TOP_KEY    = 11;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES      = 8;
  localparam longint unsigned PI_FX = 64'd3373259426;
  localparam logic [31:0] HALF_PHASE = 32'h7FFF_FFFF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hA5;

  localparam int unsigned FREQ_HZ [NOTES] = '{
    65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
    130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
    261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
    523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
    1046, 1108, 1174, 1244, 1318, 1396, 1479, 1567, 1661, 1760, 1864, 1975,
    2093, 2217, 2349, 2489, 2637, 2793, 2959, 3135, 3322, 3520, 3729, 3951,
    4186, 4434, 4698, 4978, 5274, 5587, 5919, 6271, 6644, 7040, 7458, 7902
  };

  localparam wave_e PH_WAVE [PHASES] = '{WAVE_SAW, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SINE,
                                         WAVE_SAW, WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE};
  localparam int PH_GAIN  [PHASES] = '{8, 0, 15, 8, 0, 3, 9, 1};
  localparam int PH_IDLE  [PHASES] = '{0, 51, 0, 23, 51, 0, 23, 51};
  localparam int PH_PRESS [PHASES] = '{40, 20, 30, 15, 35, 25, 40, 20};
  localparam int PH_REL   [PHASES] = '{10, 30, 20, 35, 15, 25, 10, 30};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  req_t                  req_i       = '0;
  logic                  busy_o;
  logic                  res_valid_o;
  res_t                  res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  polyphonic_nco_voice_mixer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state.
  logic [31:0] note_step [NOTES];
  int          sine_tab  [SINE_LEN];
  logic [31:0] osc_step  [VOICES];
  logic [31:0] osc_phase [VOICES];
  logic [4:0]  osc_count = '0;
  wave_e       wave_sel  = WAVE_SAW;
  logic [3:0]  gain_sel  = 4'd4;

  req_t pending_reqs [$];
  res_t expected_samples [$];
  int   held_notes [$];
  int   idle_pct    = 0;
  bit   drain_hold  = 1'b0;
  int   error_count = 0;

  // Taylor series in Q30 on the first quadrant, folded by symmetry.
  function automatic int sine_value(int unsigned i);
    longint unsigned x, x2, t, s, v;
    bit neg;
    int k;
    x = (64'd2 * PI_FX * i) / SINE_LEN;
    neg = 1'b0;
    if (x >= PI_FX) begin
      x = x - PI_FX;
      neg = 1'b1;
    end
    if (x > PI_FX / 2) x = PI_FX - x;
    x2 = (x * x) >> 30;
    t = x;
    s = x;
    for (k = 1; k <= 9; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = (s > t) ? s - t : 64'd0;
      else s = s + t;
    end
    v = (64'd127 * s + 64'd16384) >> 30;
    if (v > 127) v = 127;
    return neg ? -int'(v) : int'(v);
  endfunction

  function automatic res_t mix_tick(logic [14:0] bend);
    int acc, gain, p;
    logic [63:0] prod;
    logic [31:0] ph, idx;
    res_t r;
    gain = (gain_sel > 4'd8) ? 8 : int'(gain_sel);
    acc = 0;
    for (p = 0; p < int'(osc_count); p++) begin
      prod = 64'(osc_step[p]) * 64'(bend);
      osc_phase[p] = osc_phase[p] + prod[45:14];
      ph = osc_phase[p];
      case (wave_sel)
        WAVE_SAW:    acc += int'(ph[31:24]) - 128;
        WAVE_SQUARE: acc += (ph < HALF_PHASE) ? 63 : -64;
        WAVE_TRIANGLE: begin
          if (ph >= HALF_PHASE) ph = 32'd0 - ph;
          acc += int'(ph[31:24]);
        end
        default: begin
          prod = 64'(ph) * 64'(SINE_LEN - 1);
          idx = prod[63:32];
          acc += sine_tab[idx];
        end
      endcase
    end
    // The saw is scaled by a flooring shift, the others by gain/8 toward zero.
    if (wave_sel == WAVE_SAW) acc = acc >>> (8 - gain);
    else acc = (acc * gain) / 8;
    if (osc_count != 0) acc = acc / int'(osc_count);
    else acc = 0;
    acc += (wave_sel == WAVE_SQUARE) ? 64 : 128;
    r.sample_out    = 9'(acc);
    r.active_voices = osc_count;
    return r;
  endfunction

  function automatic void apply_req(req_t r);
    int note, p;
    logic [31:0] step;
    bit hit;
    if (r.operation == OP_TICK) begin
      expected_samples.push_back(mix_tick(r.pitch_bend));
    end else if (r.operation == OP_PRESS || r.operation == OP_RELEASE) begin
      note = 12 * (int'(r.octave) - LOW_OCTAVE) + int'(r.key);
      if (int'(r.octave) >= LOW_OCTAVE && int'(r.key) <= TOP_KEY && note < NOTES) begin
        step = note_step[note];
        if (r.operation == OP_PRESS) begin
          if (osc_count < VOICES) begin
            osc_step[osc_count] = step;
            osc_count++;
          end
        end else begin
          // Steps after the first match slide down; phases stay where they are.
          hit = 1'b0;
          for (p = 0; p < int'(osc_count); p++) begin
            if (hit) osc_step[p-1] = osc_step[p];
            else if (osc_step[p] == step) hit = 1'b1;
          end
          if (hit) osc_count--;
        end
      end
    end
  endfunction

  // Driver: a new request goes out only when the current one has been taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) apply_req(req_i);
      if (!(start_i && busy_o)) begin
        if (drain_hold && expected_samples.size() == 0) drain_hold = 1'b0;
        if (pending_reqs.size() > 0 && !drain_hold && $urandom_range(0, 99) >= idle_pct) begin
          req_i   <= pending_reqs.pop_front();
          start_i <= 1'b1;
          if ($urandom_range(0, 149) == 0) drain_hold = 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got sample_out %0d active_voices %0d",
                 $time, res_o.sample_out, res_o.active_voices);
      end else begin
        want = expected_samples.pop_front();
        if (res_o.sample_out !== want.sample_out) begin
          error_count++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want.sample_out, res_o.sample_out);
        end
        if (res_o.active_voices !== want.active_voices) begin
          error_count++;
          $display("%0t: active_voices mismatch, expected %0d, got %0d",
                   $time, want.active_voices, res_o.active_voices);
        end
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] op, int oct, int key, int bend);
    req_t r;
    r.operation  = op;
    r.octave     = 4'(oct);
    r.key        = 4'(key);
    r.pitch_bend = 15'(bend);
    return r;
  endfunction

  function automatic logic [14:0] pick_bend();
    case ($urandom_range(0, 9))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      2:       return 15'd16384;
      3, 4, 5: return 15'($urandom_range(12000, 21000));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  // Waits until every request is taken and every sample has come, then lets
  // a trailing press or release finish.
  task automatic wait_drain();
    while (pending_reqs.size() > 0 || start_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_WAVEFORM) wave_sel = wave_e'(data[1:0]);
    else if (idx == CFG_VOLUME) gain_sel = data[3:0];
    @(posedge clk_i);
  endtask

  task automatic gen_phase(int n, int press_w, int rel_w);
    int i, pick, note, slot;
    req_t r;
    logic [24:0] raw;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      r.octave     = 4'($urandom_range(0, 15));
      r.key        = 4'($urandom_range(0, 15));
      r.pitch_bend = pick_bend();
      if (pick < 45) begin
        r.operation = OP_TICK;
      end else if (pick < 45 + press_w) begin
        r.operation = OP_PRESS;
        if (held_notes.size() > 0 && $urandom_range(0, 4) == 0)
          note = held_notes[$urandom_range(0, held_notes.size() - 1)];
        else
          note = $urandom_range(0, NOTES - 1);
        if (held_notes.size() < 24) held_notes.push_back(note);
        r.octave = 4'(note / 12 + LOW_OCTAVE);
        r.key    = 4'(note % 12);
      end else if (pick < 45 + press_w + rel_w) begin
        r.operation = OP_RELEASE;
        if (held_notes.size() > 0 && $urandom_range(0, 4) != 0) begin
          slot = $urandom_range(0, held_notes.size() - 1);
          note = held_notes[slot];
          held_notes.delete(slot);
        end else begin
          note = $urandom_range(0, NOTES - 1);
        end
        r.octave = 4'(note / 12 + LOW_OCTAVE);
        r.key    = 4'(note % 12);
      end else begin
        // Broken requests: the unused code or a note outside the table.
        raw = 25'($urandom);
        r = raw;
        case ($urandom_range(0, 2))
          0: r.operation = OP_UNUSED;
          1: begin
            r.operation = $urandom_range(0, 1) ? OP_PRESS : OP_RELEASE;
            r.octave = $urandom_range(0, 1) ? 4'($urandom_range(0, 1))
                                            : 4'($urandom_range(9, 15));
          end
          default: begin
            r.operation = $urandom_range(0, 1) ? OP_PRESS : OP_RELEASE;
            r.key = 4'($urandom_range(12, 15));
          end
        endcase
      end
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    int i, ph;
    logic [CFG_DATA_W-1:0] data;
    for (i = 0; i < NOTES; i++)
      note_step[i] = 32'((64'(FREQ_HZ[i]) << 32) / 64'd22050);
    for (i = 0; i < SINE_LEN; i++) sine_tab[i] = sine_value(i);
    for (i = 0; i < VOICES; i++) begin
      osc_step[i]  = '0;
      osc_phase[i] = '0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset settings.
    pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 16384));      // empty table
    pending_reqs.push_back(mk_req(OP_RELEASE, 4, 0, 0));       // release on empty table
    pending_reqs.push_back(mk_req(OP_UNUSED, 15, 15, 32767));
    pending_reqs.push_back(mk_req(OP_PRESS, 2, 0, 0));         // lowest note
    pending_reqs.push_back(mk_req(OP_PRESS, 8, 11, 32767));    // highest note
    pending_reqs.push_back(mk_req(OP_PRESS, 1, 5, 0));
    pending_reqs.push_back(mk_req(OP_PRESS, 4, 12, 0));
    pending_reqs.push_back(mk_req(OP_PRESS, 15, 15, 0));
    pending_reqs.push_back(mk_req(OP_PRESS, 9, 0, 0));         // note just past the table
    pending_reqs.push_back(mk_req(OP_TICK, 15, 15, 32767));
    pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 0));
    pending_reqs.push_back(mk_req(OP_RELEASE, 5, 3, 0));       // no match
    pending_reqs.push_back(mk_req(OP_PRESS, 2, 0, 0));         // duplicate step
    pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 16384));
    pending_reqs.push_back(mk_req(OP_RELEASE, 2, 0, 0));       // first of the pair
    pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 16384));
    pending_reqs.push_back(mk_req(OP_RELEASE, 8, 11, 0));
    pending_reqs.push_back(mk_req(OP_RELEASE, 2, 0, 0));
    pending_reqs.push_back(mk_req(OP_TICK, 7, 9, 16384));
    pending_reqs.push_back(mk_req(OP_TICK, 0, 0, 1));
    wait_drain();

    for (ph = 0; ph < PHASES; ph++) begin
      data = $urandom_range(0, 1) ? 32'($urandom) : '0;
      data[1:0] = PH_WAVE[ph];
      write_reg(CFG_WAVEFORM, data);
      data = $urandom_range(0, 1) ? 32'($urandom) : '0;
      data[3:0] = 4'(PH_GAIN[ph]);
      write_reg(CFG_VOLUME, data);
      if (ph == 3) write_reg(CFG_UNUSED, 32'($urandom));
      idle_pct = PH_IDLE[ph];
      gen_phase(140, PH_PRESS[ph], PH_REL[ph]);
      wait_drain();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/pnvm_pkg.sv
hdl/pnvm_div.sv
hdl/polyphonic_nco_voice_mixer.sv
verif/tb.sv
